// ===== src/sfcd_pkg.sv =====
package sfcd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned IndexW = 2;
  localparam int unsigned PosW   = 3;

  // CRC-8 constants: polynomial 0x31, preset 0xFF, MSB first.
  localparam logic [ByteW-1:0] CRC_POLY = 8'h31;
  localparam logic [ByteW-1:0] CRC_INIT = 8'hFF;

  // Byte positions inside one six-byte group.
  localparam logic [PosW-1:0] POS_FIRST = 3'd0;
  localparam logic [PosW-1:0] POS_CRC_A = 3'd2;
  localparam logic [PosW-1:0] POS_CRC_B = 3'd5;

  // Registered input item handed from the input stage to the decoder.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
    logic             frame_start;
  } sfcd_item_t;

  // One byte through the CRC-8 shift register, unrolled over eight bits.
  function automatic logic [ByteW-1:0] crc8_step(logic [ByteW-1:0] crc,
                                                  logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== src/sfcd_if.sv =====
interface sfcd_in_if;
  import sfcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             frame_start;

  modport source(output valid, output rx_byte, output frame_start, input ready);
  modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcd_out_if;
  import sfcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WordW-1:0]  value_word;
  logic [IndexW-1:0] value_index;
  logic              crc_ok;
  logic              last_value;

  modport source(output valid, output value_word, output value_index,
                 output crc_ok, output last_value, input ready);
  modport sink(input valid, input value_word, input value_index,
               input crc_ok, input last_value, output ready);
endinterface

// ===== src/sensor_frame_crc_word_decoder.sv =====
// Channel  Dir  Payload                                        Accepted when
// rx_i     in   rx_byte[7:0], frame_start                      valid && ready
// tx_o     out  value_word[31:0], value_index[1:0], crc_ok,    valid && ready
//               last_value
//
// One byte is accepted per cycle into an input register; the CRC/assembly
// logic feeds the result register, which takes a result from the closing
// CRC byte in the input register. One result leaves for every six bytes.
// Reset clears alignment to byte 0 with the CRC preset to 0xFF.
// A stalled result holds the result register; bytes that make no result
// keep flowing, and the input stalls only behind a waiting result.
module sensor_frame_crc_word_decoder #(
  parameter int unsigned VALUES_PER_FRAME = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfcd_in_if.sink     rx_i,
  sfcd_out_if.source  tx_o
);
  import sfcd_pkg::*;

  localparam logic [IndexW-1:0] LastIdx = IndexW'(VALUES_PER_FRAME - 1);

  sfcd_item_t item;
  logic       adv;

  sfcd_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .adv_i  (adv),
    .item_o (item)
  );

  sfcd_decode #(
    .VALUES_PER_FRAME(VALUES_PER_FRAME)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .adv_o  (adv),
    .tx_o   (tx_o)
  );

  // With the result slot empty the input is never stalled.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tx_o.valid |-> rx_i.ready)
    else $error("input stalled with an empty result slot");

  // A new result only appears after the decoder consumed an item.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tx_o.valid) |-> $past(adv))
    else $error("result appeared without a consumed item");

  // The last marker goes only with the final group index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.last_value) |-> (tx_o.value_index == LastIdx))
    else $error("last marker on a wrong group index");

endmodule

// ===== src/sfcd_in_reg.sv =====
module sfcd_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfcd_in_if.sink             rx_i,
  input  logic                adv_i,
  output sfcd_pkg::sfcd_item_t item_o
);
  import sfcd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             start_q;
  logic             take;

  // The stage takes a new item when it is empty or its item moves on now.
  assign rx_i.ready = !valid_q || adv_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded on accept and needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= rx_i.rx_byte;
      start_q <= rx_i.frame_start;
    end
  end

  assign item_o.valid       = valid_q;
  assign item_o.rx_byte     = byte_q;
  assign item_o.frame_start = start_q;

endmodule

// ===== src/sfcd_decode.sv =====
module sfcd_decode #(
  parameter int unsigned VALUES_PER_FRAME = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfcd_pkg::sfcd_item_t item_i,
  output logic                 adv_o,
  sfcd_out_if.source           tx_o
);
  import sfcd_pkg::*;

  localparam int unsigned GrpW = (VALUES_PER_FRAME > 1) ? $clog2(VALUES_PER_FRAME) : 1;
  localparam logic [GrpW-1:0] LastGrp = GrpW'(VALUES_PER_FRAME - 1);

  // Frame state.
  logic [PosW-1:0]  pos_q, pos_d;
  logic [GrpW-1:0]  grp_q, grp_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [WordW-1:0] word_q, word_d;
  logic             err_q, err_d;

  // State as seen by the current item after a frame restart.
  logic [PosW-1:0]  pos_e;
  logic [GrpW-1:0]  grp_e;
  logic [ByteW-1:0] crc_e;
  logic [WordW-1:0] word_e;
  logic             err_e;
  logic             is_crc, emit, mismatch;
  logic [GrpW+1:0]  grp_ext;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_word_q;
  logic [IndexW-1:0] out_index_q;
  logic              out_ok_q;
  logic              out_last_q;

  // A frame start clears the partial group, restarts at group 0 and realigns to byte 0.
  always_comb begin
    pos_e  = item_i.frame_start ? POS_FIRST : pos_q;
    grp_e  = item_i.frame_start ? '0 : grp_q;
    crc_e  = item_i.frame_start ? CRC_INIT : crc_q;
    word_e = item_i.frame_start ? '0 : word_q;
    err_e  = item_i.frame_start ? 1'b0 : err_q;
  end

  assign is_crc   = (pos_e == POS_CRC_A) || (pos_e == POS_CRC_B);
  assign emit     = (pos_e == POS_CRC_B);
  assign mismatch = (item_i.rx_byte != crc_e);
  assign grp_ext  = {2'b00, grp_e};

  // The item moves on unless it makes a result and the result slot stays full.
  assign adv_o = item_i.valid && (!emit || !out_valid_q || tx_o.ready);

  // Next frame state for the item being consumed.
  always_comb begin
    pos_d  = pos_q;
    grp_d  = grp_q;
    crc_d  = crc_q;
    word_d = word_q;
    err_d  = err_q;
    if (adv_o) begin
      if (emit) begin
        pos_d  = POS_FIRST;
        grp_d  = (grp_e == LastGrp) ? '0 : grp_e + 1'b1;
        crc_d  = CRC_INIT;
        word_d = '0;
        err_d  = 1'b0;
      end else if (is_crc) begin
        pos_d  = pos_e + 1'b1;
        grp_d  = grp_e;
        crc_d  = CRC_INIT;
        word_d = word_e;
        err_d  = err_e || mismatch;
      end else begin
        pos_d  = pos_e + 1'b1;
        grp_d  = grp_e;
        crc_d  = crc8_step(crc_e, item_i.rx_byte);
        word_d = {word_e[WordW-ByteW-1:0], item_i.rx_byte};
        err_d  = err_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_FIRST;
      grp_q  <= '0;
      crc_q  <= CRC_INIT;
      word_q <= '0;
      err_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      grp_q  <= grp_d;
      crc_q  <= crc_d;
      word_q <= word_d;
      err_q  <= err_d;
    end
  end

  // Result slot: filled by a closing CRC byte, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_o && emit) begin
      out_valid_d = 1'b1;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && emit) begin
      out_word_q  <= word_e;
      out_index_q <= grp_ext[IndexW-1:0];
      out_ok_q    <= !(err_e || mismatch);
      out_last_q  <= (grp_e == LastGrp);
    end
  end

  assign tx_o.valid       = out_valid_q;
  assign tx_o.value_word  = out_word_q;
  assign tx_o.value_index = out_index_q;
  assign tx_o.crc_ok      = out_ok_q;
  assign tx_o.last_value  = out_last_q;

endmodule
